// File: rtl/mtfc_pkg.sv
// Shared types and constants for the mux TLV frame checker.
`default_nettype none

package mtfc_pkg;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned HDR_BYTES = 13;

	// register index, paddr[3:2]
	localparam logic [1:0] REG_MARKER = 2'd0;
	localparam logic [1:0] REG_CTL_SVC = 2'd1;
	localparam logic [1:0] REG_SEARCH = 2'd2;

	localparam logic [7:0] MARKER_RESET = 8'd1;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_MARKER = 3'd1;
	localparam logic [2:0] ST_MUX_SHORT = 3'd2;
	localparam logic [2:0] ST_MUX_LEN = 3'd3;
	localparam logic [2:0] ST_HDR_SHORT = 3'd4;
	localparam logic [2:0] ST_TLV_LEN = 3'd5;
	localparam logic [2:0] ST_TLV_HDR = 3'd6;
	localparam logic [2:0] ST_TLV_VAL = 3'd7;

	localparam logic [16:0] POS_MAX = 17'h1FFFF;
	localparam logic [16:0] FRAME_MAX = 17'h10000;

	typedef struct packed {
		logic [7:0] marker_value;
		logic [7:0] control_service_id;
		logic [7:0] search_type;
	} cfg_t;

	typedef struct packed {
		logic [2:0] status;
		logic is_control;
		logic [7:0] service_id;
		logic [7:0] client_num;
		logic [7:0] mux_flags;
		logic [7:0] msg_flags;
		logic [15:0] txn_num;
		logic [15:0] msg_num;
		logic [16:0] frame_bytes;
		logic tlv_found;
		logic [15:0] tlv_value_offset;
		logic [15:0] tlv_value_length;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/mux_tlv_frame_checker.sv
// Top level: byte input register, frame parser, result register.
//
//   channel   direction  handshake              payload
//   cfg       in         psel/penable/pready    paddr, pwdata, prdata
//   in        in         in_valid/in_ready      frame_byte, last_byte
//   out       out        out_valid/out_ready    status .. tlv_value_length
//
// One byte is taken per cycle unless the input stalls; a byte waits in the
// input register until the parser steps on it, and a final byte loads the
// result register as it leaves, so a result is presented once the parser has
// stepped on the final byte. Input stalls only when a final byte waits in the
// input register and the result register still holds an untaken result.
// arst_n clears all frame state and loads register reset values.
`default_nettype none

module mux_tlv_frame_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [mtfc_pkg::ADDR_W-1:0] paddr,
	input wire logic [mtfc_pkg::DATA_W-1:0] pwdata,
	output logic [mtfc_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] frame_byte,
	input wire logic last_byte,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] status,
	output logic is_control,
	output logic [7:0] service_id,
	output logic [7:0] client_num,
	output logic [7:0] mux_flags,
	output logic [7:0] msg_flags,
	output logic [15:0] txn_num,
	output logic [15:0] msg_num,
	output logic [16:0] frame_bytes,
	output logic tlv_found,
	output logic [15:0] tlv_value_offset,
	output logic [15:0] tlv_value_length
);
	import mtfc_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t res_q;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic out_valid_q;
	logic step;

	assign pready = 1'b1;

	mtfc_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.cfg(cfg)
	);

	// hold a final byte while the result register is still full
	assign step = valid_s1 && !(last_s1 && out_valid_q && !out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= frame_byte;
			last_s1 <= last_byte;
		end
	end

	mtfc_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.step(step),
		.byte_in(byte_s1),
		.last_in(last_s1),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign is_control = res_q.is_control;
	assign service_id = res_q.service_id;
	assign client_num = res_q.client_num;
	assign mux_flags = res_q.mux_flags;
	assign msg_flags = res_q.msg_flags;
	assign txn_num = res_q.txn_num;
	assign msg_num = res_q.msg_num;
	assign frame_bytes = res_q.frame_bytes;
	assign tlv_found = res_q.tlv_found;
	assign tlv_value_offset = res_q.tlv_value_offset;
	assign tlv_value_length = res_q.tlv_value_length;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && last_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a pending result");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_s1) |=> out_valid_q)
		else $error("final byte did not produce a result");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && tlv_found) |-> (status == ST_OK))
		else $error("TLV reported on a failed frame");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !tlv_found) |-> (tlv_value_offset == 16'd0 &&
			tlv_value_length == 16'd0))
		else $error("TLV fields nonzero without a match");

endmodule

`default_nettype wire

// File: rtl/mtfc_cfg.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module mtfc_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [mtfc_pkg::ADDR_W-1:0] paddr,
	input wire logic [mtfc_pkg::DATA_W-1:0] pwdata,
	output logic [mtfc_pkg::DATA_W-1:0] prdata,
	output mtfc_pkg::cfg_t cfg
);
	import mtfc_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [1:0] idx;

	assign idx = paddr[3:2];
	assign wr_en = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.marker_value <= MARKER_RESET;
			cfg_q.control_service_id <= '0;
			cfg_q.search_type <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_MARKER: cfg_q.marker_value <= pwdata[7:0];
				REG_CTL_SVC: cfg_q.control_service_id <= pwdata[7:0];
				REG_SEARCH: cfg_q.search_type <= pwdata[7:0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MARKER: prdata = {24'd0, cfg_q.marker_value};
			REG_CTL_SVC: prdata = {24'd0, cfg_q.control_service_id};
			REG_SEARCH: prdata = {24'd0, cfg_q.search_type};
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/mtfc_parse.sv
// Per-frame state, header capture, TLV walk and final status logic.
`default_nettype none

module mtfc_parse (
	input wire logic clk,
	input wire logic arst_n,
	input wire mtfc_pkg::cfg_t cfg,
	input wire logic step,
	input wire logic [7:0] byte_in,
	input wire logic last_in,
	output mtfc_pkg::res_t res
);
	import mtfc_pkg::*;

	logic [16:0] pos_q, pos_u;
	logic marker_ok_q, marker_ok_u;
	logic [7:0] hdr_q [HDR_BYTES];
	logic [7:0] hdr_u [HDR_BYTES];
	logic armed_q, armed_u;
	logic ctl_q, ctl_u;
	logic [16:0] next_q, next_u;
	logic [1:0] hcnt_q, hcnt_u;
	logic [7:0] ttype_q, ttype_u;
	logic [7:0] tlen_lo_q, tlen_lo_u;
	logic match_q, match_u;
	logic [15:0] moff_q, moff_u;
	logic [15:0] mlen_q, mlen_u;

	logic [17:0] vstart;
	logic [17:0] tend;
	logic [15:0] tlen_full;

	logic ctl_f;
	logic [15:0] mux_len;
	logic [15:0] hl;
	logic [15:0] tlv_len;
	logic [16:0] len_m1;
	logic too_big;
	logic [2:0] st;

	// byte-wise state update
	always_comb begin
		pos_u = (pos_q < POS_MAX) ? pos_q + 17'd1 : POS_MAX;
		marker_ok_u = marker_ok_q;
		hdr_u = hdr_q;
		armed_u = armed_q;
		ctl_u = ctl_q;
		next_u = next_q;
		hcnt_u = hcnt_q;
		ttype_u = ttype_q;
		tlen_lo_u = tlen_lo_q;
		match_u = match_q;
		moff_u = moff_q;
		mlen_u = mlen_q;

		tlen_full = {byte_in, tlen_lo_q};
		vstart = {1'b0, next_q} + 18'd3;
		tend = vstart + {2'b00, tlen_full};

		if (pos_q < 17'(HDR_BYTES))
			hdr_u[pos_q[3:0]] = byte_in;
		if (pos_q == 17'd0)
			marker_ok_u = (byte_in == cfg.marker_value);

		if (pos_q == 17'd4) begin
			ctl_u = (byte_in == cfg.control_service_id);
			next_u = ctl_u ? 17'd12 : 17'd13;
			armed_u = 1'b1;
		end else if (armed_q) begin
			case (hcnt_q)
				2'd0: begin
					if (pos_q == next_q) begin
						ttype_u = byte_in;
						hcnt_u = 2'd1;
					end
				end
				2'd1: begin
					tlen_lo_u = byte_in;
					hcnt_u = 2'd2;
				end
				default: begin
					if (!match_q && ttype_q == cfg.search_type) begin
						match_u = 1'b1;
						moff_u = vstart[15:0];
						mlen_u = tlen_full;
					end
					next_u = (tend > {1'b0, POS_MAX}) ? POS_MAX : tend[16:0];
					hcnt_u = 2'd0;
				end
			endcase
		end
	end

	// final status from the state after this byte
	always_comb begin
		ctl_f = armed_u ? ctl_u : (hdr_u[4] == cfg.control_service_id);
		mux_len = {hdr_u[2], hdr_u[1]};
		hl = ctl_f ? 16'd11 : 16'd12;
		tlv_len = ctl_f ? {hdr_u[11], hdr_u[10]} : {hdr_u[12], hdr_u[11]};
		len_m1 = pos_u - 17'd1;
		too_big = pos_u > FRAME_MAX;

		if (!marker_ok_u) st = ST_BAD_MARKER;
		else if (mux_len < 16'd5) st = ST_MUX_SHORT;
		else if (too_big || {1'b0, mux_len} != len_m1) st = ST_MUX_LEN;
		else if (mux_len < hl) st = ST_HDR_SHORT;
		else if (mux_len - hl != tlv_len) st = ST_TLV_LEN;
		else if (hcnt_u != 2'd0) st = ST_TLV_HDR;
		else if (next_u > pos_u) st = ST_TLV_VAL;
		else st = ST_OK;

		res.status = st;
		res.is_control = ctl_f;
		res.service_id = hdr_u[4];
		res.client_num = hdr_u[5];
		res.mux_flags = hdr_u[3];
		res.msg_flags = hdr_u[6];
		res.txn_num = ctl_f ? {8'd0, hdr_u[7]} : {hdr_u[8], hdr_u[7]};
		res.msg_num = ctl_f ? {hdr_u[9], hdr_u[8]} : {hdr_u[10], hdr_u[9]};
		res.frame_bytes = too_big ? FRAME_MAX : pos_u;
		res.tlv_found = (st == ST_OK) && match_u;
		res.tlv_value_offset = res.tlv_found ? moff_u : 16'd0;
		res.tlv_value_length = res.tlv_found ? mlen_u : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			marker_ok_q <= 1'b0;
			for (int i = 0; i < HDR_BYTES; i++) hdr_q[i] <= '0;
			armed_q <= 1'b0;
			ctl_q <= 1'b0;
			next_q <= '0;
			hcnt_q <= '0;
			ttype_q <= '0;
			tlen_lo_q <= '0;
			match_q <= 1'b0;
			moff_q <= '0;
			mlen_q <= '0;
		end else if (step) begin
			if (last_in) begin
				// frame done: clear for the next one
				pos_q <= '0;
				marker_ok_q <= 1'b0;
				for (int i = 0; i < HDR_BYTES; i++) hdr_q[i] <= '0;
				armed_q <= 1'b0;
				ctl_q <= 1'b0;
				next_q <= '0;
				hcnt_q <= '0;
				ttype_q <= '0;
				tlen_lo_q <= '0;
				match_q <= 1'b0;
				moff_q <= '0;
				mlen_q <= '0;
			end else begin
				pos_q <= pos_u;
				marker_ok_q <= marker_ok_u;
				hdr_q <= hdr_u;
				armed_q <= armed_u;
				ctl_q <= ctl_u;
				next_q <= next_u;
				hcnt_q <= hcnt_u;
				ttype_q <= ttype_u;
				tlen_lo_q <= tlen_lo_u;
				match_q <= match_u;
				moff_q <= moff_u;
				mlen_q <= mlen_u;
			end
		end
	end

endmodule

`default_nettype wire

// File: test/tb_mux_tlv_frame_checker.sv
// Self-checking testbench for the mux TLV frame checker: random and directed frames.
`default_nettype none

module tb_mux_tlv_frame_checker;
	import mtfc_pkg::*;

	localparam int unsigned RUN_LIMIT = 2_000_000;

	typedef logic [7:0] byte_q_t[$];

	class frame_scoreboard;
		logic [7:0] marker_value;
		logic [7:0] control_service_id;
		logic [7:0] search_type;

		int unsigned pos;
		bit marker_ok;
		logic [7:0] hdr [HDR_BYTES];
		bit walk_armed;
		bit ctl_latched;
		int unsigned next_tlv;
		int unsigned hdr_count;
		logic [7:0] tlv_type;
		logic [15:0] tlv_len;
		bit match_valid;
		logic [15:0] match_off;
		logic [15:0] match_len;

		res_t pending_verdicts[$];
		int errors;
		int frames;
		int hits;
		int status_seen[8];

		function void clear_frame();
			pos = 0;
			marker_ok = 0;
			foreach (hdr[i]) hdr[i] = '0;
			walk_armed = 0;
			ctl_latched = 0;
			next_tlv = 0;
			hdr_count = 0;
			tlv_type = '0;
			tlv_len = '0;
			match_valid = 0;
			match_off = '0;
			match_len = '0;
		endfunction

		function void power_on();
			marker_value = MARKER_RESET;
			control_service_id = '0;
			search_type = '0;
			clear_frame();
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				REG_MARKER: marker_value = val;
				REG_CTL_SVC: control_service_id = val;
				REG_SEARCH: search_type = val;
				default: ;
			endcase
		endfunction

		// Advance the frame walk by one accepted byte; queue a verdict on the final byte.
		function void note_byte(logic [7:0] b, logic lst);
			int unsigned p, vstart, stop, len, mux, hl, tl;
			bit ctl;
			logic [2:0] st;
			res_t r;
			p = pos;
			if (p < HDR_BYTES) hdr[p] = b;
			if (p == 0) marker_ok = (b == marker_value);
			if (p == 4) begin
				ctl_latched = (b == control_service_id);
				next_tlv = ctl_latched ? 12 : 13;
				walk_armed = 1;
			end else if (walk_armed) begin
				if (hdr_count == 0) begin
					if (p == next_tlv) begin
						tlv_type = b;
						hdr_count = 1;
					end
				end else if (hdr_count == 1) begin
					tlv_len = {8'h00, b};
					hdr_count = 2;
				end else begin
					tlv_len[15:8] = b;
					vstart = next_tlv + 3;
					stop = vstart + tlv_len;
					if (stop > POS_MAX) stop = POS_MAX;
					if (!match_valid && tlv_type == search_type) begin
						match_valid = 1;
						match_off = vstart[15:0];
						match_len = tlv_len;
					end
					next_tlv = stop;
					hdr_count = 0;
				end
			end
			pos = (p < POS_MAX) ? p + 1 : POS_MAX;
			if (!lst) return;

			len = pos;
			mux = {hdr[2], hdr[1]};
			// short frames never saw the service byte: decide from the live register
			ctl = walk_armed ? ctl_latched : (hdr[4] == control_service_id);
			hl = ctl ? 11 : 12;
			tl = ctl ? {hdr[11], hdr[10]} : {hdr[12], hdr[11]};
			if (!marker_ok) st = ST_BAD_MARKER;
			else if (mux < 5) st = ST_MUX_SHORT;
			else if (len > FRAME_MAX || mux != len - 1) st = ST_MUX_LEN;
			else if (mux < hl) st = ST_HDR_SHORT;
			else if (mux - hl != tl) st = ST_TLV_LEN;
			else if (hdr_count != 0) st = ST_TLV_HDR;
			else if (next_tlv > len) st = ST_TLV_VAL;
			else st = ST_OK;

			r.status = st;
			r.is_control = ctl;
			r.service_id = hdr[4];
			r.client_num = hdr[5];
			r.mux_flags = hdr[3];
			r.msg_flags = hdr[6];
			r.txn_num = ctl ? {8'h00, hdr[7]} : {hdr[8], hdr[7]};
			r.msg_num = ctl ? {hdr[9], hdr[8]} : {hdr[10], hdr[9]};
			r.frame_bytes = (len > FRAME_MAX) ? FRAME_MAX : len[16:0];
			r.tlv_found = (st == ST_OK) && match_valid;
			r.tlv_value_offset = r.tlv_found ? match_off : 16'h0000;
			r.tlv_value_length = r.tlv_found ? match_len : 16'h0000;
			pending_verdicts.push_back(r);
			clear_frame();
		endfunction

		function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
			if (exp_v != act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending_verdicts.size() == 0) begin
				$error("result with no frame outstanding: status %0d", got.status);
				errors++;
				return;
			end
			want = pending_verdicts.pop_front();
			frames++;
			if (want.tlv_found) hits++;
			status_seen[want.status]++;
			cmp("status", want.status, got.status);
			cmp("is_control", want.is_control, got.is_control);
			cmp("service_id", want.service_id, got.service_id);
			cmp("client_num", want.client_num, got.client_num);
			cmp("mux_flags", want.mux_flags, got.mux_flags);
			cmp("msg_flags", want.msg_flags, got.msg_flags);
			cmp("txn_num", want.txn_num, got.txn_num);
			cmp("msg_num", want.msg_num, got.msg_num);
			cmp("frame_bytes", want.frame_bytes, got.frame_bytes);
			cmp("tlv_found", want.tlv_found, got.tlv_found);
			cmp("tlv_value_offset", want.tlv_value_offset, got.tlv_value_offset);
			cmp("tlv_value_length", want.tlv_value_length, got.tlv_value_length);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] frame_byte = 8'h00;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic is_control;
	logic [7:0] service_id;
	logic [7:0] client_num;
	logic [7:0] mux_flags;
	logic [7:0] msg_flags;
	logic [15:0] txn_num;
	logic [15:0] msg_num;
	logic [16:0] frame_bytes;
	logic tlv_found;
	logic [15:0] tlv_value_offset;
	logic [15:0] tlv_value_length;

	frame_scoreboard sb;
	int idle_pct = 0;
	int stall_pct = 0;
	int unsigned cycles = 0;

	mux_tlv_frame_checker u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.frame_byte(frame_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.is_control(is_control),
		.service_id(service_id),
		.client_num(client_num),
		.mux_flags(mux_flags),
		.msg_flags(msg_flags),
		.txn_num(txn_num),
		.msg_num(msg_num),
		.frame_bytes(frame_bytes),
		.tlv_found(tlv_found),
		.tlv_value_offset(tlv_value_offset),
		.tlv_value_length(tlv_value_length)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin : watch
		res_t got;
		cycles++;
		if (arst_n && out_valid && out_ready) begin
			got.status = status;
			got.is_control = is_control;
			got.service_id = service_id;
			got.client_num = client_num;
			got.mux_flags = mux_flags;
			got.msg_flags = msg_flags;
			got.txn_num = txn_num;
			got.msg_num = msg_num;
			got.frame_bytes = frame_bytes;
			got.tlv_found = tlv_found;
			got.tlv_value_offset = tlv_value_offset;
			got.tlv_value_length = tlv_value_length;
			sb.check_result(got);
		end
		if (arst_n && in_valid && in_ready) sb.note_byte(frame_byte, last_byte);
	end

	initial begin
		while (cycles < RUN_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d frames outstanding", cycles,
			sb.pending_verdicts.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// Leave psel and penable as they are: the caller closes the last access.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(input logic [7:0] marker, input logic [7:0] ctl_svc,
			input logic [7:0] search);
		write_reg(REG_MARKER, marker);
		write_reg(REG_CTL_SVC, ctl_svc);
		write_reg(REG_SEARCH, search);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic lst);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		frame_byte <= b;
		last_byte <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_frame(input byte_q_t q);
		for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
	endtask

	// Hold the input until every frame has its verdict, then let the pipe settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic byte_q_t tlv_body(int n, int maxlen);
		byte_q_t q;
		int len;
		for (int i = 0; i < n; i++) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(maxlen * 6) : $urandom_range(maxlen);
			q.push_back(($urandom_range(3) == 0) ? sb.search_type : 8'($urandom));
			q.push_back(len[7:0]);
			q.push_back(len[15:8]);
			repeat (len) q.push_back(8'($urandom));
		end
		return q;
	endfunction

	// Wrap a TLV area in a mux header and a control or service header with matching lengths.
	function automatic byte_q_t framed(bit ctl, byte_q_t body);
		byte_q_t q;
		logic [15:0] mux;
		logic [15:0] tl;
		logic [7:0] svc;
		tl = 16'(body.size());
		mux = tl + (ctl ? 16'd11 : 16'd12);
		svc = 8'($urandom);
		if (ctl) svc = sb.control_service_id;
		else while (svc == sb.control_service_id) svc = 8'($urandom);
		q.push_back(sb.marker_value);
		q.push_back(mux[7:0]);
		q.push_back(mux[15:8]);
		q.push_back(8'($urandom));
		q.push_back(svc);
		repeat (ctl ? 5 : 6) q.push_back(8'($urandom));
		q.push_back(tl[7:0]);
		q.push_back(tl[15:8]);
		foreach (body[i]) q.push_back(body[i]);
		return q;
	endfunction

	function automatic byte_q_t random_frame();
		byte_q_t q;
		bit ctl;
		int k;
		int cut;
		ctl = $urandom_range(1);
		k = $urandom_range(99);
		if (k < 10) begin
			// consistent lengths around a TLV area of loose bytes
			repeat ($urandom_range(10)) q.push_back(8'($urandom));
			return framed(ctl, q);
		end
		q = framed(ctl, tlv_body($urandom_range(4), 8));
		if (k < 64) return q;
		if (k < 68) q[0] ^= 8'($urandom_range(255, 1));
		else if (k < 74) q[$urandom_range(2, 1)] ^= 8'($urandom_range(255, 1));
		else if (k < 80) q[(ctl ? 10 : 11) + $urandom_range(1)] ^= 8'($urandom_range(255, 1));
		else if (k < 92) begin
			cut = $urandom_range(q.size() - 1, 1);
			while (q.size() > cut) void'(q.pop_back());
			if (cut >= 3 && $urandom_range(1)) begin
				q[1] = 8'(cut - 1);
				q[2] = 8'((cut - 1) >> 8);
			end
		end else begin
			q.delete();
			repeat ($urandom_range(24, 1)) q.push_back(8'($urandom));
			if ($urandom_range(1)) q[0] = sb.marker_value;
		end
		return q;
	endfunction

	initial begin : stimulus
		byte_q_t q;
		int sent;
		int idle_of[4];
		int stall_of[4];
		idle_of = '{0, 70, 0, 19};
		stall_of = '{0, 0, 70, 19};
		sb = new;
		sb.power_on();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames under the reset register values
		q = framed(1, {8'h00, 8'h02, 8'h00, 8'hAA, 8'h55, 8'h07, 8'h00, 8'h00});
		send_frame(q);
		send_frame(framed(0, tlv_body(3, 6)));
		q = framed(0, {8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'hFF});
		for (int i = 3; i <= 10; i++) q[i] = 8'hFF;
		send_frame(q);
		send_frame(framed(1, tlv_body(0, 0)));
		q = framed(1, tlv_body(1, 4));
		q[0] = ~q[0];
		send_frame(q);
		send_frame({sb.marker_value, 8'h04, 8'h00, 8'h00, 8'h00});
		q = framed(0, tlv_body(2, 4));
		q[1] ^= 8'h01;
		send_frame(q);
		send_frame({sb.marker_value, 8'h08, 8'h00, 8'h5A, 8'h00, 8'h3C, 8'h81, 8'h7E, 8'h24});
		q = framed(1, tlv_body(2, 4));
		q[10] ^= 8'h01;
		send_frame(q);
		send_frame(framed(0, {8'h05, 8'h01}));
		send_frame(framed(1, {8'h05, 8'h04, 8'h00, 8'h11}));
		send_frame({sb.marker_value});
		send_frame({sb.marker_value, 8'h06, 8'h00});

		for (int ph = 0; ph < 4; ph++) begin
			for (int half = 0; half < 2; half++) begin
				drain_results();
				if (ph == 0 && half == 0) configure(8'h00, 8'hFF, 8'hFF);
				else if (ph == 1 && half == 0) configure(8'hFF, 8'h00, 8'h00);
				else configure(8'($urandom), 8'($urandom), 8'($urandom));
				idle_pct = idle_of[ph];
				stall_pct = stall_of[ph];
				sent = 0;
				while (sent < 210) begin
					q = random_frame();
					send_frame(q);
					sent += q.size();
				end
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_verdicts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("checked %0d frames in %0d cycles, %0d of them with a TLV hit",
			sb.frames, cycles, sb.hits);
		$display("frames per status ok..value overrun: %0d %0d %0d %0d %0d %0d %0d %0d",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
			sb.status_seen[4], sb.status_seen[5], sb.status_seen[6], sb.status_seen[7]);
		if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
rtl/mtfc_pkg.sv
rtl/mtfc_cfg.sv
rtl/mtfc_parse.sv
rtl/mux_tlv_frame_checker.sv
test/tb_mux_tlv_frame_checker.sv
